[rtl/core/pidsr_pkg.sv]
// ----------------------------------------------------------------------------
// pidsr_pkg
// Register map and fixed field widths of the PID speed regulator.
// ----------------------------------------------------------------------------
package pidsr_pkg;

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 20;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_GOAL        = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ERR_THRESH  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_INTEG   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_KP          = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_KI          = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_KD          = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_SPEED_LIMIT = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_SPEED   = 3'd7;

  // Register widths
  localparam int GOAL_W   = 13;
  localparam int THRESH_W = 13;
  localparam int MAXI_W   = 20;
  localparam int GAIN_W   = 16;
  localparam int SPEED_W  = 15;

  // Stream fields
  localparam int SAMPLE_W = 16;
  localparam int OUT_W    = 16;

  // Accumulated error, signed
  localparam int INTEG_W = 21;

  // Register reset values
  localparam logic [MAXI_W-1:0]  MAXI_RST  = 20'd4096;
  localparam logic [GAIN_W-1:0]  KP_RST    = 16'd256;
  localparam logic [SPEED_W-1:0] LIMIT_RST = 15'd1100;

endpackage

[rtl/core/pid_speed_regulator.sv]
// ----------------------------------------------------------------------------
// pid_speed_regulator
// Decimating PID speed regulator with deadband, integral clamp, output limit
// and minimum output magnitude.
// ----------------------------------------------------------------------------
// Takes one request per clock unless the output stalls; requests pass the
// input register, error/integral stage, multiply stage and sum/limit stage
// with the output register. The decimation count, integral add and clamp
// and previous error close their loops in the error stage, so samples may
// follow each other in consecutive cycles. A halt request yields speed 0
// and leaves the state alone; of the other samples only one in DECIMATION
// yields a result, the rest are absorbed. The user must write registers via
// the cfg_ port only while no request is in flight, which is not enforced.
module pid_speed_regulator #(
  parameter int DECIMATION     = 4,
  parameter int INPUT_SHIFT    = 3,
  parameter int GAIN_FRAC_BITS = 8
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // configuration
  input  logic                               cfg_wr_en,
  input  logic [pidsr_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [pidsr_pkg::CFG_DATA_W-1:0]   cfg_data,
  // input stream
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [pidsr_pkg::SAMPLE_W-1:0]     in_tdata,   // [15:0] acc_sample
  input  logic                               in_tuser,   // [0] halt
  // result stream
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [pidsr_pkg::OUT_W-1:0]        out_tdata,  // [15:0] speed
  output logic                               out_tuser   // [0] at_rest
);
  import pidsr_pkg::*;

  localparam int CNT_W  = (DECIMATION > 1) ? $clog2(DECIMATION) : 1;
  localparam int SCL_W  = SAMPLE_W - INPUT_SHIFT;
  localparam int ERR_W  = ((SCL_W > GOAL_W) ? SCL_W : GOAL_W) + 1;
  localparam int DIFF_W = ERR_W + 1;
  localparam int MAG_W  = (ERR_W > THRESH_W) ? ERR_W : THRESH_W;
  localparam int ISUM_W = INTEG_W + 1;
  localparam int PKP_W  = GAIN_W + ERR_W;
  localparam int PKI_W  = GAIN_W + INTEG_W;
  localparam int PKD_W  = GAIN_W + DIFF_W;
  localparam int ACC_W  = PKI_W + 2;
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DECIMATION - 1);
  localparam logic [SAMPLE_W-1:0] IN_BIAS = SAMPLE_W'((32'd1 << INPUT_SHIFT) - 1);
  localparam logic [ACC_W-1:0] ACC_BIAS = ACC_W'((64'd1 << GAIN_FRAC_BITS) - 1);

  // configuration registers
  logic signed [GOAL_W-1:0]  goal_r;
  logic [THRESH_W-1:0]       thresh_r;
  logic [MAXI_W-1:0]         maxi_r;
  logic signed [GAIN_W-1:0]  kp_r, ki_r, kd_r;
  logic [SPEED_W-1:0]        limit_r, min_r;

  // regulator state
  logic [CNT_W-1:0]          cnt_r, cnt_nxt;
  logic signed [INTEG_W-1:0] integ_r, integ_nxt;
  logic signed [ERR_W-1:0]   last_r, last_nxt;

  // input register
  logic                      a_v_r;
  logic signed [SAMPLE_W-1:0] a_smp_r;
  logic                      a_halt_r;

  // error stage
  logic                      b_v_r, b_zero_r;
  logic signed [ERR_W-1:0]   b_err_r;
  logic signed [INTEG_W-1:0] b_int_r;
  logic signed [DIFF_W-1:0]  b_diff_r;

  // multiply stage
  logic                      c_v_r, c_zero_r;
  logic signed [PKP_W-1:0]   c_pkp_r;
  logic signed [PKI_W-1:0]   c_pki_r;
  logic signed [PKD_W-1:0]   c_pkd_r;

  // output register
  logic                      out_v_r, rest_r;
  logic [OUT_W-1:0]          speed_r;

  // flow control, bubbles collapse
  logic out_free, c_free, b_free, a_skip, a_pass, a_go;

  assign out_free  = !out_v_r || out_tready;
  assign c_free    = !c_v_r || out_free;
  assign b_free    = !b_v_r || c_free;
  assign a_skip    = !a_halt_r && (cnt_r != CNT_LAST);
  assign a_pass    = !a_skip;
  assign a_go      = a_v_r && (a_skip || b_free);
  assign in_tready = !a_v_r || a_go;

  // write configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      goal_r   <= '0;
      thresh_r <= '0;
      maxi_r   <= MAXI_RST;
      kp_r     <= KP_RST;
      ki_r     <= '0;
      kd_r     <= '0;
      limit_r  <= LIMIT_RST;
      min_r    <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_GOAL:        goal_r   <= cfg_data[GOAL_W-1:0];
        REG_ERR_THRESH:  thresh_r <= cfg_data[THRESH_W-1:0];
        REG_MAX_INTEG:   maxi_r   <= cfg_data[MAXI_W-1:0];
        REG_KP:          kp_r     <= cfg_data[GAIN_W-1:0];
        REG_KI:          ki_r     <= cfg_data[GAIN_W-1:0];
        REG_KD:          kd_r     <= cfg_data[GAIN_W-1:0];
        REG_SPEED_LIMIT: limit_r  <= cfg_data[SPEED_W-1:0];
        REG_MIN_SPEED:   min_r    <= cfg_data[SPEED_W-1:0];
        default: ;
      endcase
    end
  end

  // capture the request
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
    end else if (in_tready) begin
      a_v_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      a_smp_r  <= in_tdata;
      a_halt_r <= in_tuser;
    end
  end

  // scale the sample, form the error, update the integral
  logic signed [SAMPLE_W-1:0] smp_biased;
  logic signed [SAMPLE_W-1:0] smp_shift;
  logic signed [SCL_W-1:0]    scaled;
  logic signed [ERR_W-1:0]    err;
  logic [ERR_W-1:0]           err_mag;
  logic                       in_dead;
  logic signed [ISUM_W-1:0]   isum, imax_pos, imax_neg, iclamp;
  logic signed [DIFF_W-1:0]   diff;

  always_comb begin
    smp_biased = a_smp_r + (a_smp_r[SAMPLE_W-1] ? IN_BIAS : '0);
    smp_shift  = smp_biased >>> INPUT_SHIFT;
    scaled     = smp_shift[SCL_W-1:0];
    err        = ERR_W'(scaled) - ERR_W'(goal_r);
    err_mag    = err[ERR_W-1] ? ERR_W'(-err) : err;
    in_dead    = MAG_W'(err_mag) < MAG_W'(thresh_r);

    imax_pos = $signed({{(ISUM_W-MAXI_W){1'b0}}, maxi_r});
    imax_neg = -imax_pos;
    isum     = ISUM_W'(integ_r) + ISUM_W'(err);
    if (isum > imax_pos) begin
      iclamp = imax_pos;
    end else if (isum < imax_neg) begin
      iclamp = imax_neg;
    end else begin
      iclamp = isum;
    end
    diff = DIFF_W'(err) - DIFF_W'(last_r);

    // hold state unless a sample is absorbed or used
    cnt_nxt   = cnt_r;
    integ_nxt = integ_r;
    last_nxt  = last_r;
    if (a_go && !a_halt_r) begin
      if (a_skip) begin
        cnt_nxt = cnt_r + 1'b1;
      end else begin
        cnt_nxt = '0;
        if (in_dead) begin
          integ_nxt = '0;
          last_nxt  = '0;
        end else begin
          integ_nxt = iclamp[INTEG_W-1:0];
          last_nxt  = err;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r   <= '0;
      integ_r <= '0;
      last_r  <= '0;
    end else begin
      cnt_r   <= cnt_nxt;
      integ_r <= integ_nxt;
      last_r  <= last_nxt;
    end
  end

  // error stage register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_v_r <= 1'b0;
    end else if (b_free) begin
      b_v_r <= a_v_r && a_pass;
    end
  end

  always_ff @(posedge clk) begin
    if (b_free && a_v_r && a_pass) begin
      b_zero_r <= a_halt_r || in_dead;
      b_err_r  <= err;
      b_int_r  <= iclamp[INTEG_W-1:0];
      b_diff_r <= diff;
    end
  end

  // multiply by the gains
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_v_r <= 1'b0;
    end else if (c_free) begin
      c_v_r <= b_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (c_free && b_v_r) begin
      c_zero_r <= b_zero_r;
      c_pkp_r  <= kp_r * b_err_r;
      c_pki_r  <= ki_r * b_int_r;
      c_pkd_r  <= kd_r * b_diff_r;
    end
  end

  // sum, drop fraction toward zero, limit, apply minimum, zero on halt or deadband
  logic signed [ACC_W-1:0] acc, acc_biased, s_trunc, s_lim;
  logic signed [ACC_W-1:0] lim_pos, lim_neg, min_pos, min_neg;

  always_comb begin
    acc        = ACC_W'(c_pkp_r) + ACC_W'(c_pki_r) + ACC_W'(c_pkd_r);
    acc_biased = acc + (acc[ACC_W-1] ? ACC_BIAS : '0);
    s_trunc    = acc_biased >>> GAIN_FRAC_BITS;
    lim_pos    = $signed({{(ACC_W-SPEED_W){1'b0}}, limit_r});
    lim_neg    = -lim_pos;
    min_pos    = $signed({{(ACC_W-SPEED_W){1'b0}}, min_r});
    min_neg    = -min_pos;
    if (s_trunc < lim_neg) begin
      s_lim = lim_neg;
    end else if (s_trunc > lim_pos) begin
      s_lim = lim_pos;
    end else if (s_trunc > 0 && s_trunc < min_pos) begin
      s_lim = min_pos;
    end else if (s_trunc < 0 && s_trunc > min_neg) begin
      s_lim = min_neg;
    end else begin
      s_lim = s_trunc;
    end
    if (c_zero_r) begin
      s_lim = '0;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (out_free) begin
      out_v_r <= c_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && c_v_r) begin
      speed_r <= s_lim[OUT_W-1:0];
      rest_r  <= (s_lim == '0);
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = speed_r;
  assign out_tuser  = rest_r;

  // checks
  a_rest_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r |-> (rest_r == (speed_r == '0)))
    else $error("at_rest does not match speed");

  a_halt_keeps: assert property (@(posedge clk) disable iff (!rst_n)
    (a_go && a_halt_r) |=> (cnt_r == $past(cnt_r) && integ_r == $past(integ_r)
                            && last_r == $past(last_r)))
    else $error("halt changed regulator state");

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_LAST)
    else $error("decimation count out of range");

  a_integ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (a_go && a_pass && !a_halt_r) |=>
      ((integ_r[INTEG_W-1] ? -ISUM_W'(integ_r) : ISUM_W'(integ_r))
         <= $signed({{(ISUM_W-MAXI_W){1'b0}}, $past(maxi_r)})))
    else $error("integral exceeds clamp");

  a_skip_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (a_go && a_skip && b_free) |=> !b_v_r)
    else $error("absorbed sample produced a result");

endmodule

[tb/testbench.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Checks the PID speed regulator over its input and result streams. Every
// request taken at the input runs through a local regulator model: it holds
// its own copy of the registers, the integral, the previous error and the
// decimation count, and queues the speed command each request should produce.
// Results are matched in order against that queue. Directed requests cover the
// field extremes, halt, the deadband and the minimum-speed corners, then
// random phases with new register settings run under varied idling and one
// long output stall.
// ----------------------------------------------------------------------------
module testbench;
  import pidsr_pkg::*;

  localparam int DECIMATION     = 4;
  localparam int INPUT_SHIFT    = 3;
  localparam int GAIN_FRAC_BITS = 8;
  localparam int SETTLE_CYCLES  = 16;
  localparam int HOLD_CYCLES    = 400;
  localparam int PHASE_ITEMS    = 112;
  localparam int MAX_REPORTS    = 10;

  typedef enum {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

  typedef struct packed {
    logic [OUT_W-1:0] speed;
    logic             at_rest;
  } speed_cmd_t;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_wr_en;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [SAMPLE_W-1:0]   in_tdata;   // [15:0] acc_sample
  logic                  in_tuser;   // [0] halt
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_W-1:0]      out_tdata;  // [15:0] speed
  logic                  out_tuser;  // [0] at_rest

  // Model registers
  logic signed [GOAL_W-1:0] goal_r;
  logic [THRESH_W-1:0]      thresh_r;
  logic [MAXI_W-1:0]        max_integ_r;
  logic signed [GAIN_W-1:0] kp_r;
  logic signed [GAIN_W-1:0] ki_r;
  logic signed [GAIN_W-1:0] kd_r;
  logic [SPEED_W-1:0]       limit_r;
  logic [SPEED_W-1:0]       min_speed_r;

  // Model state
  longint integ_q;
  longint last_err_q;
  int     decim_q;

  speed_cmd_t speed_queue[$];
  int         fail_count;
  int         send_idle_pct;
  int         recv_stall_pct;
  int         hold_ticket;
  int         hold_seen;
  int         hold_cnt;

  pid_speed_regulator #(
    .DECIMATION    (DECIMATION),
    .INPUT_SHIFT   (INPUT_SHIFT),
    .GAIN_FRAC_BITS(GAIN_FRAC_BITS)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  always #5 clk = ~clk;

  // Run one accepted request through the regulator model and queue its result
  function automatic void regulate_sample(input logic signed [SAMPLE_W-1:0] sample,
                                          input logic halt);
    longint     smp;
    longint     err;
    longint     mag;
    longint     sum;
    longint     acc;
    longint     s;
    longint     lim;
    longint     mn;
    longint     maxi;
    speed_cmd_t cmd;
    smp  = longint'(sample);
    lim  = longint'(limit_r);
    mn   = longint'(min_speed_r);
    maxi = longint'(max_integ_r);
    if (halt) begin
      cmd.speed   = '0;
      cmd.at_rest = 1'b1;
      speed_queue.push_back(cmd);
      return;
    end
    // Absorb all but one sample in DECIMATION
    if (decim_q + 1 < DECIMATION) begin
      decim_q++;
      return;
    end
    decim_q = 0;
    err = smp / (longint'(1) << INPUT_SHIFT) - longint'(goal_r);
    mag = (err < 0) ? -err : err;
    if (mag < longint'(thresh_r)) begin
      integ_q    = 0;
      last_err_q = 0;
      s          = 0;
    end else begin
      sum = integ_q + err;
      if (sum > maxi) sum = maxi;
      else if (sum < -maxi) sum = -maxi;
      integ_q = sum;
      acc = longint'(kp_r) * err + longint'(ki_r) * integ_q
          + longint'(kd_r) * (err - last_err_q);
      s = acc / (longint'(1) << GAIN_FRAC_BITS);
      last_err_q = err;
      // Limit first, then lift small nonzero values to the minimum
      if (s < -lim) s = -lim;
      else if (s > lim) s = lim;
      else if (s > 0 && s < mn) s = mn;
      else if (s < 0 && s > -mn) s = -mn;
    end
    cmd.speed   = s[OUT_W-1:0];
    cmd.at_rest = (s == 0);
    speed_queue.push_back(cmd);
  endfunction

  function automatic void apply_reg(input logic [CFG_IDX_W-1:0] idx,
                                    input logic [CFG_DATA_W-1:0] val);
    case (idx)
      REG_GOAL:        goal_r      = val[GOAL_W-1:0];
      REG_ERR_THRESH:  thresh_r    = val[THRESH_W-1:0];
      REG_MAX_INTEG:   max_integ_r = val[MAXI_W-1:0];
      REG_KP:          kp_r        = val[GAIN_W-1:0];
      REG_KI:          ki_r        = val[GAIN_W-1:0];
      REG_KD:          kd_r        = val[GAIN_W-1:0];
      REG_SPEED_LIMIT: limit_r     = val[SPEED_W-1:0];
      REG_MIN_SPEED:   min_speed_r = val[SPEED_W-1:0];
      default: ;
    endcase
  endfunction

  // Random register value; high garbage bits show up in the wide draws
  function automatic logic [CFG_DATA_W-1:0] rand_reg(input logic [CFG_IDX_W-1:0] idx);
    int pick;
    int v;
    pick = $urandom_range(0, 2);
    v    = $urandom;
    case (idx)
      REG_GOAL:       if (pick == 0) v = $urandom_range(0, 128) - 64;
      REG_ERR_THRESH: if (pick == 0) v = 0;
                      else if (pick == 1) v = $urandom_range(0, 40);
      REG_MAX_INTEG:  if (pick == 0) v = $urandom_range(0, 200);
                      else if (pick == 1) v = $urandom_range(0, 100000);
      REG_KP, REG_KI, REG_KD:
                      if (pick != 2) v = $urandom_range(0, 2048) - 1024;
      REG_SPEED_LIMIT, REG_MIN_SPEED:
                      if (pick != 2) v = $urandom_range(0, 2000);
      default: ;
    endcase
    return v[CFG_DATA_W-1:0];
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] pick_sample();
    int v;
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 3))
          0: v = 32767;
          1: v = -32768;
          2: v = 0;
          default: v = -1;
        endcase
      end
      1, 2, 3: begin
        // Hover around the goal so the deadband edge is crossed often
        v = int'(goal_r) * 8 + $urandom_range(0, 2 * (int'(thresh_r) * 8 + 64))
          - (int'(thresh_r) * 8 + 64);
        if (v > 32767) v = 32767;
        if (v < -32768) v = -32768;
      end
      default: v = $urandom;
    endcase
    return v[SAMPLE_W-1:0];
  endfunction

  task automatic note_failure(input string what, input int want, input int got);
    fail_count++;
    if (fail_count <= MAX_REPORTS)
      $display("mismatch %s: expected %0d, got %0d", what, want, got);
  endtask

  // Offer one request, with random idle cycles ahead of it, and wait for the take
  task automatic send_sample(input logic signed [SAMPLE_W-1:0] sample, input logic halt);
    @(negedge clk);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= sample;
    in_tuser  <= halt;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    regulate_sample(sample, halt);
  endtask

  // Drop valid, drain all results, then let absorbed samples leave the pipe
  task automatic wait_idle();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (speed_queue.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    apply_reg(idx, val);
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic set_idling(input idle_mode_t mode);
    case (mode)
      IDLE_NONE:     begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      IDLE_SENDER:   begin send_idle_pct = 87; recv_stall_pct = 0;  end
      IDLE_RECEIVER: begin send_idle_pct = 0;  recv_stall_pct = 87; end
      default:       begin send_idle_pct = 8;  recv_stall_pct = 8;  end
    endcase
  endtask

  // Three random fillers, then the sample that the decimation actually uses
  task automatic send_used_sample(input logic signed [SAMPLE_W-1:0] sample);
    repeat (DECIMATION - 1) send_sample(SAMPLE_W'($urandom), 1'b0);
    send_sample(sample, 1'b0);
  endtask

  // Reset settings: halt and both input extremes, clamped to the speed limit
  task automatic test_reset_defaults();
    set_idling(IDLE_NONE);
    send_sample(16'sh7fff, 1'b1);
    send_used_sample(16'sh7fff);
    send_used_sample(-16'sh8000);
  endtask

  // Deadband, truncation to zero ahead of the minimum, minimum above the limit
  task automatic test_special_cases();
    wait_idle();
    write_reg(REG_GOAL, '0);
    write_reg(REG_ERR_THRESH, 20'd5);
    write_reg(REG_MAX_INTEG, '0);
    write_reg(REG_KP, 20'd1);
    write_reg(REG_KI, '0);
    write_reg(REG_KD, '0);
    write_reg(REG_SPEED_LIMIT, 20'd100);
    write_reg(REG_MIN_SPEED, 20'd200);
    set_idling(IDLE_BOTH);
    send_used_sample(16'sd32);
    send_used_sample(16'sd40);
    send_used_sample(16'sh7fff);
    send_used_sample(-16'sh8000);
  endtask

  task automatic load_config(input int setting);
    if (setting == 1) begin
      write_reg(REG_GOAL, 20'(-4096));
      write_reg(REG_ERR_THRESH, '0);
      write_reg(REG_MAX_INTEG, '0);
      write_reg(REG_KP, 20'(-32768));
      write_reg(REG_KI, 20'(-32768));
      write_reg(REG_KD, 20'(-32768));
      write_reg(REG_SPEED_LIMIT, '0);
      write_reg(REG_MIN_SPEED, '0);
    end else if (setting == 2) begin
      write_reg(REG_GOAL, 20'd4095);
      write_reg(REG_ERR_THRESH, 20'd8191);
      write_reg(REG_MAX_INTEG, 20'hfffff);
      write_reg(REG_KP, 20'd32767);
      write_reg(REG_KI, 20'd32767);
      write_reg(REG_KD, 20'd32767);
      write_reg(REG_SPEED_LIMIT, 20'd32767);
      write_reg(REG_MIN_SPEED, 20'd32767);
    end else begin
      write_reg(REG_GOAL, rand_reg(REG_GOAL));
      write_reg(REG_ERR_THRESH, rand_reg(REG_ERR_THRESH));
      write_reg(REG_MAX_INTEG, rand_reg(REG_MAX_INTEG));
      write_reg(REG_KP, rand_reg(REG_KP));
      write_reg(REG_KI, rand_reg(REG_KI));
      write_reg(REG_KD, rand_reg(REG_KD));
      write_reg(REG_SPEED_LIMIT, rand_reg(REG_SPEED_LIMIT));
      write_reg(REG_MIN_SPEED, rand_reg(REG_MIN_SPEED));
    end
  endtask

  // Random phases, each with fresh registers and its own idling pattern
  task automatic test_random_phases();
    for (int p = 0; p < 8; p++) begin
      wait_idle();
      load_config(p);
      set_idling(idle_mode_t'(p % 4));
      repeat (PHASE_ITEMS) send_sample(pick_sample(), $urandom_range(0, 99) < 15);
    end
  endtask

  // Hold the output off for a long stretch while requests keep coming
  task automatic test_output_stall();
    wait_idle();
    set_idling(IDLE_NONE);
    hold_ticket++;
    repeat (80) send_sample(pick_sample(), 1'($urandom_range(0, 1)));
  endtask

  // Output ready: random stalls plus the long hold-off on request
  always @(negedge clk) begin
    if (hold_ticket != hold_seen) begin
      hold_seen = hold_ticket;
      hold_cnt  = HOLD_CYCLES;
    end
    if (hold_cnt > 0) begin
      hold_cnt--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // Match each taken result against the oldest queued speed command
  always @(posedge clk) begin
    speed_cmd_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (speed_queue.size() == 0) begin
        note_failure("unexpected result speed", 0, int'($signed(out_tdata)));
      end else begin
        want = speed_queue.pop_front();
        if (out_tdata !== want.speed)
          note_failure("speed", int'($signed(want.speed)), int'($signed(out_tdata)));
        if (out_tuser !== want.at_rest)
          note_failure("at_rest", int'(want.at_rest), int'(out_tuser));
      end
    end
  end

  initial begin
    #10_000_000;
    $display("tb: failure");
    $finish;
  end

  initial begin
    clk            = 1'b0;
    rst_n          = 1'b0;
    cfg_wr_en      = 1'b0;
    cfg_index      = '0;
    cfg_data       = '0;
    in_tvalid      = 1'b0;
    in_tdata       = '0;
    in_tuser       = 1'b0;
    out_tready     = 1'b0;
    fail_count     = 0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_ticket    = 0;
    hold_seen      = 0;
    hold_cnt       = 0;
    goal_r         = '0;
    thresh_r       = '0;
    max_integ_r    = MAXI_RST;
    kp_r           = KP_RST;
    ki_r           = '0;
    kd_r           = '0;
    limit_r        = LIMIT_RST;
    min_speed_r    = '0;
    integ_q        = 0;
    last_err_q     = 0;
    decim_q        = 0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_reset_defaults();
    test_special_cases();
    test_random_phases();
    test_output_stall();
    wait_idle();

    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/core/pidsr_pkg.sv
rtl/core/pid_speed_regulator.sv
tb/testbench.sv
